@@ hdl/lzwd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package lzwd_pkg;
   localparam int DictSize  = 4096;
   localparam int MaxWidth  = 12;
   localparam int MaxString = 64;
   localparam int AddrW     = $clog2(DictSize);
   localparam int CodeW     = 16;
   localparam int NextW     = $clog2(DictSize + 1);
   localparam int StackW    = $clog2(MaxString);
   localparam int StackCntW = $clog2(MaxString + 1);

   localparam logic [CodeW-1:0] CodeEnd       = CodeW'(16'h100);
   localparam logic [CodeW-1:0] CodeWiden     = CodeW'(16'h101);
   localparam logic [CodeW-1:0] CodeClear     = CodeW'(16'h102);
   localparam logic [CodeW-1:0] CodeFirstFree = CodeW'(16'h103);
   localparam logic [4:0]       StartWidth    = 5'd9;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_TRUNC = 2'd1,
      ST_SAT   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LITERAL,
      OP_EXPAND,
      OP_SAT,
      OP_END
   } op_type;

   typedef struct packed {
      op_type           op;
      logic [CodeW-1:0] code;
      logic             group_first;
      logic             done;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_READ,
      BK_WALK,
      BK_EMIT
   } back_state_type;
endpackage
`default_nettype wire

@@ hdl/lzwd_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface lzwd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_end;
   modport source (output valid, output in_byte, output in_end, input ready);
   modport sink   (input valid, input in_byte, input in_end, output ready);
endinterface

interface lzwd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       run_last;
   logic       stream_done;
   logic [1:0] status;
   modport source (output valid, output out_byte, output byte_valid, output run_last,
                   output stream_done, output status, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                   input stream_done, input status, output ready);
endinterface
`default_nettype wire

@@ hdl/lzwd_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lzwd_front
   import lzwd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire logic [7:0] in_byte,
   input  wire logic    in_end,
   output logic         cmd_valid,
   input  wire logic    cmd_ready,
   output cmd_type      cmd
);
   logic [23:0] bit_buffer_ff, bit_buffer_in;
   logic [4:0]  bit_count_ff, bit_count_in;
   logic [4:0]  code_width_ff, code_width_in;
   logic        group_start_ff, group_start_in;
   logic        stopped_ff, stopped_in;
   logic [23:0] buf_w;
   logic [4:0]  cnt_w, rem;
   logic [CodeW-1:0] code;
   logic        take;
   logic        stop_now;

   // stopped items produce nothing; accept and drop
   assign in_ready = stopped_ff | cmd_ready;
   assign take     = in_valid & in_ready & ~stopped_ff;

   always_comb begin
      bit_buffer_in  = bit_buffer_ff;
      bit_count_in   = bit_count_ff;
      code_width_in  = code_width_ff;
      group_start_in = group_start_ff;
      stopped_in     = stopped_ff;
      buf_w          = {bit_buffer_ff[15:0], in_byte};
      cnt_w          = bit_count_ff + 5'd8;
      rem            = cnt_w - code_width_ff;
      code           = CodeW'((buf_w >> rem) & ((24'd1 << code_width_ff) - 24'd1));
      cmd            = '{op: OP_NONE, code: code, group_first: group_start_ff, done: 1'b0};
      stop_now       = 1'b0;
      if (cnt_w >= code_width_ff) begin
         if (group_start_ff) begin
            if (code == CodeEnd) stop_now = 1'b1;
            else begin
               cmd.op = OP_LITERAL;
               group_start_in = 1'b0;
            end
         end else if (code == CodeEnd) begin
            stop_now = 1'b1;
         end else if (code == CodeClear) begin
            group_start_in = 1'b1;
            code_width_in  = StartWidth;
         end else if (code == CodeWiden) begin
            if (code_width_ff < 5'(MaxWidth)) code_width_in = code_width_ff + 5'd1;
            else cmd.op = OP_SAT;
         end else begin
            cmd.op = OP_EXPAND;
         end
      end
      if (in_end) stop_now = 1'b1;
      cmd.done = stop_now;
      if (stop_now && cmd.op == OP_NONE) cmd.op = OP_END;
      if (take) begin
         if (cnt_w >= code_width_ff) begin
            bit_count_in  = rem;
            bit_buffer_in = buf_w & ((24'd1 << rem) - 24'd1);
         end else begin
            bit_count_in  = cnt_w;
            bit_buffer_in = buf_w;
         end
         if (stop_now) stopped_in = 1'b1;
      end else begin
         bit_buffer_in  = bit_buffer_ff;
         bit_count_in   = bit_count_ff;
         code_width_in  = code_width_ff;
         group_start_in = group_start_ff;
      end
   end

   assign cmd_valid = take;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_buffer_ff  <= '0;
         bit_count_ff   <= '0;
         code_width_ff  <= StartWidth;
         group_start_ff <= 1'b1;
         stopped_ff     <= 1'b0;
      end else begin
         bit_buffer_ff  <= bit_buffer_in;
         bit_count_ff   <= bit_count_in;
         code_width_ff  <= code_width_in;
         group_start_ff <= group_start_in;
         stopped_ff     <= stopped_in;
      end
   end
endmodule
`default_nettype wire

@@ hdl/lzwd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lzwd_queue
   import lzwd_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push_valid,
   output logic      push_ready,
   input  cmd_type   push_data,
   output logic      pop_valid,
   input  wire logic pop_ready,
   output cmd_type   pop_data
);
   cmd_type    slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign push_ready = cnt_ff != 2'd2;
   assign pop_valid  = cnt_ff != 2'd0;
   assign pop_data   = slot_ff[rd_ff];
   assign push = push_valid & push_ready;
   assign pop  = pop_valid & pop_ready;

   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_data;
   end
endmodule
`default_nettype wire

@@ hdl/lzwd_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lzwd_back
   import lzwd_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic cmd_valid,
   output logic      cmd_ready,
   input  cmd_type   cmd,
   lzwd_rsp_if.source rsp
);
   logic [AddrW-1:0] prefix_mem [DictSize];
   logic [7:0]       suffix_mem [DictSize];
   logic [7:0]       stack_mem  [MaxString];

   back_state_type   state_ff, state_in;
   logic [NextW-1:0] next_code_ff, next_code_in;
   logic [CodeW-1:0] prev_ff, prev_in;
   logic [7:0]       first_ff, first_in;
   cmd_type          cur_ff, cur_in;
   logic [CodeW-1:0] walk_ff, walk_in;
   logic [StackCntW-1:0] n_ff, n_in;
   logic             trunc_ff, trunc_in;
   logic [7:0]       newfirst_ff, newfirst_in;

   logic             rv_ff, rv_in;
   logic [7:0]       rb_ff, rb_in;
   logic             rbv_ff, rbv_in, rl_ff, rl_in, rd_ff, rd_in;
   logic [1:0]       rs_ff, rs_in;

   logic [AddrW-1:0] rd_addr;
   logic [AddrW-1:0] pre_q;
   logic [7:0]       suf_q, stk_q;
   logic             out_free;
   logic             push_en, dict_we;
   logic [7:0]       push_val;
   logic [StackW-1:0] push_idx, pop_idx;

   assign out_free = ~rv_ff | rsp.ready;
   assign rsp.valid       = rv_ff;
   assign rsp.out_byte    = rb_ff;
   assign rsp.byte_valid  = rbv_ff;
   assign rsp.run_last    = rl_ff;
   assign rsp.stream_done = rd_ff;
   assign rsp.status      = rs_ff;

   always_comb begin
      state_in     = state_ff;
      next_code_in = next_code_ff;
      prev_in      = prev_ff;
      first_in     = first_ff;
      cur_in       = cur_ff;
      walk_in      = walk_ff;
      n_in         = n_ff;
      trunc_in     = trunc_ff;
      newfirst_in  = newfirst_ff;
      rv_in  = rv_ff & ~rsp.ready;
      rb_in  = rb_ff;
      rbv_in = rbv_ff;
      rl_in  = rl_ff;
      rd_in  = rd_ff;
      rs_in  = rs_ff;
      cmd_ready = 1'b0;
      push_en   = 1'b0;
      push_val  = '0;
      dict_we   = 1'b0;
      rd_addr   = walk_ff[AddrW-1:0];
      pop_idx   = StackW'(n_ff - StackCntW'(1));
      push_idx  = n_ff[StackW-1:0];
      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_ready = 1'b1;
               cur_in = cmd;
               if (cmd.group_first) next_code_in = NextW'(CodeFirstFree);
               case (cmd.op)
                  OP_LITERAL: begin
                     rv_in = 1'b1; rb_in = cmd.code[7:0]; rbv_in = 1'b1;
                     rl_in = 1'b1; rd_in = cmd.done; rs_in = ST_OK;
                     first_in = cmd.code[7:0];
                     prev_in  = cmd.code;
                  end
                  OP_SAT: begin
                     rv_in = 1'b1; rb_in = '0; rbv_in = 1'b0;
                     rl_in = 1'b1; rd_in = cmd.done; rs_in = ST_SAT;
                  end
                  OP_END: begin
                     rv_in = 1'b1; rb_in = '0; rbv_in = 1'b0;
                     rl_in = 1'b1; rd_in = 1'b1; rs_in = ST_OK;
                  end
                  OP_EXPAND: begin
                     trunc_in = 1'b0;
                     if (CodeW'(cmd.code) >= CodeW'(next_code_ff)) begin
                        push_en  = 1'b1;
                        push_val = first_ff;
                        push_idx = '0;
                        n_in     = StackCntW'(1);
                        walk_in  = prev_ff;
                     end else begin
                        n_in    = '0;
                        walk_in = cmd.code;
                     end
                     state_in = BK_READ;
                  end
                  default: ;
               endcase
            end
         end
         BK_READ: begin
            // dictionary read issued; data next cycle
            if (walk_ff <= CodeW'(8'hFF)) begin
               if (n_ff < StackCntW'(MaxString)) begin
                  push_en = 1'b1; push_val = walk_ff[7:0];
                  n_in = n_ff + StackCntW'(1);
                  newfirst_in = walk_ff[7:0];
               end else begin
                  trunc_in = 1'b1;
               end
               state_in = BK_EMIT;
               dict_we  = 1'b1;
            end else if (n_ff >= StackCntW'(MaxString)) begin
               trunc_in = 1'b1;
               state_in = BK_EMIT;
               dict_we  = 1'b1;
            end else begin
               state_in = BK_WALK;
            end
         end
         BK_WALK: begin
            push_en = 1'b1;
            n_in = n_ff + StackCntW'(1);
            if (walk_ff < CodeW'(DictSize)) begin
               push_val = suf_q;
               walk_in  = CodeW'(pre_q);
            end else begin
               push_val = '0;
               walk_in  = '0;
            end
            newfirst_in = push_val;
            rd_addr  = walk_in[AddrW-1:0];
            state_in = BK_READ;
         end
         BK_EMIT: begin
            if (out_free) begin
               rv_in  = 1'b1;
               rb_in  = stk_q;
               rbv_in = 1'b1;
               rs_in  = trunc_ff ? ST_TRUNC : ST_OK;
               rd_in  = cur_ff.done;
               rl_in  = (n_ff == StackCntW'(1));
               n_in   = n_ff - StackCntW'(1);
               pop_idx = StackW'(n_ff - StackCntW'(2));
               if (n_ff == StackCntW'(1)) begin
                  state_in = BK_IDLE;
                  prev_in  = cur_ff.code;
                  first_in = newfirst_ff;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
      if (dict_we && next_code_ff < NextW'(DictSize)) next_code_in = next_code_ff + NextW'(1);
   end

   // Stack read: in BK_READ, top entry (earliest gathered is index 0 when truncated)
   logic [StackW-1:0] stk_addr;
   logic [7:0]        nf_w;
   always_comb begin
      stk_addr = pop_idx;
      nf_w = newfirst_in;
      if (state_ff == BK_READ) stk_addr = push_en ? push_idx : pop_idx;
   end

   always_ff @(posedge clock) begin
      if (dict_we && next_code_ff < NextW'(DictSize)) begin
         prefix_mem[next_code_ff[AddrW-1:0]] <= prev_ff[AddrW-1:0];
         suffix_mem[next_code_ff[AddrW-1:0]] <= nf_w;
      end
      pre_q <= prefix_mem[rd_addr];
      suf_q <= suffix_mem[rd_addr];
   end

   logic [7:0] stk_wr_data_ff;
   logic       stk_fwd_ff;
   logic [7:0] stk_raw;
   always_ff @(posedge clock) begin
      if (push_en) stack_mem[push_idx] <= push_val;
      stk_raw        <= stack_mem[stk_addr];
      stk_fwd_ff     <= push_en & (push_idx == stk_addr);
      stk_wr_data_ff <= push_val;
   end
   assign stk_q = stk_fwd_ff ? stk_wr_data_ff : stk_raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         next_code_ff <= NextW'(CodeFirstFree);
         prev_ff      <= '0;
         first_ff     <= '0;
         rv_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         next_code_ff <= next_code_in;
         prev_ff      <= prev_in;
         first_ff     <= first_in;
         rv_ff        <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      walk_ff     <= walk_in;
      n_ff        <= n_in;
      trunc_ff    <= trunc_in;
      newfirst_ff <= newfirst_in;
      rb_ff       <= rb_in;
      rbv_ff      <= rbv_in;
      rl_ff       <= rl_in;
      rd_ff       <= rd_in;
      rs_ff       <= rs_in;
   end
endmodule
`default_nettype wire

@@ hdl/lzw_stream_decoder.sv @@
// LZW stream decoder.
// req channel: one compressed byte per request, bits taken MSB first, with
// in_end marking the final byte. rsp channel: one item per decoded byte, or
// one flag item (end of stream, width saturation) with byte_valid low.
// run_last marks the final item of a request; stream_done marks every item
// of the request that stopped the stream.
// A front stage unpacks codes and classifies them combinationally as each
// request is accepted and hands them through a two-entry queue to the
// dictionary engine. An expanded string is walked through the dictionary
// (one synchronous RAM read per link, alternating read and walk states)
// and then emitted, one byte per cycle while the receiver takes them. The
// engine takes its next command only after the last byte of a string.
// Reset: synchronous, clears the bit buffer, code width (9), next code and
// flags; the dictionary needs no clearing. After the stream stops, requests
// are accepted and dropped until reset.
// A stalled receiver holds the output register; the engine waits, the queue
// fills, and req ready falls.
`timescale 1ns / 1ps
`default_nettype none
module lzw_stream_decoder
   import lzwd_pkg::*;
(
   input wire logic   clock,
   input wire logic   reset,
   lzwd_req_if.sink   req,
   lzwd_rsp_if.source rsp
);
   logic    f_valid, f_ready, b_valid, b_ready;
   cmd_type f_cmd, b_cmd;

   lzwd_front u_front (
      .clock, .reset,
      .in_valid (req.valid), .in_ready (req.ready),
      .in_byte (req.in_byte), .in_end (req.in_end),
      .cmd_valid (f_valid), .cmd_ready (f_ready), .cmd (f_cmd)
   );

   lzwd_queue u_queue (
      .clock, .reset,
      .push_valid (f_valid), .push_ready (f_ready), .push_data (f_cmd),
      .pop_valid (b_valid), .pop_ready (b_ready), .pop_data (b_cmd)
   );

   lzwd_back u_back (
      .clock, .reset,
      .cmd_valid (b_valid), .cmd_ready (b_ready), .cmd (b_cmd),
      .rsp (rsp)
   );
endmodule
`default_nettype wire

@@ hdl/lzwd_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lzwd_port_checks (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_byte_valid,
   input wire logic [7:0] rsp_out_byte,
   input wire logic [1:0] rsp_status,
   input wire logic rsp_run_last,
   input wire logic rsp_stream_done
);
   a_flag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_out_byte == 8'd0)
      else $error("flag item carries data");
   a_sat_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == 2'd2 |-> !rsp_byte_valid && rsp_run_last)
      else $error("saturation item malformed");
   a_no_status3: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("bad status");
   a_done_stays: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_stream_done && !rsp_run_last
      |=> !rsp_valid || rsp_stream_done)
      else $error("stream_done dropped within a request");
endmodule

bind lzw_stream_decoder lzwd_port_checks u_checker (
   .clock (clock), .reset (reset),
   .rsp_valid (rsp.valid), .rsp_ready (rsp.ready),
   .rsp_byte_valid (rsp.byte_valid), .rsp_out_byte (rsp.out_byte),
   .rsp_status (rsp.status), .rsp_run_last (rsp.run_last),
   .rsp_stream_done (rsp.stream_done)
);
`default_nettype wire
